// ===== rtl/val_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// val_pkg: shared constants for the vector angle and length block
// atan table for the cordic angle lane, q30, truncated
// ----------------------------------------------------------------------------
package val_pkg;

  localparam int unsigned CordicSteps = 31;
  localparam int unsigned NormBits    = 61;
  localparam int unsigned ZBits       = 34;

  localparam logic [ZBits-1:0] Q30Pi     = 34'd3373259426;
  localparam logic [ZBits-1:0] Q30HalfPi = 34'd1686629713;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/vector_angle_length.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_angle_length: length of one 2d vector and angle between two
// pipelined geometry block; unless the output stalls, one item per cycle
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one item per transfer: eight signed coordinates, the start
//   and end points of vectors a and b. m_axis returns one result per item:
//   |a| in q.8, the angle in radians in q.14 (0..pi) and a degenerate flag
//   on tuser, set when either vector has zero length (angle then 0).
//   the block is a fixed-depth pipeline: a square-root lane (one root bit
//   per stage) runs beside an angle lane (products, normalize, one cordic
//   step per stage); a merge stage joins both into the output register.
//   throughput is one transfer per cycle while the output is not stalled;
//   the pipeline is the longer of the two lanes (the root lane of 3 front
//   stages, then COORD_BITS+LENGTH_FRAC_BITS+2 root stages and a rounding
//   stage, or the 36 stages of the angle lane), plus the output register.
//   when m_axis_tready is low the whole pipeline holds (global enable), so
//   s_axis_tready follows the output register being empty or drained.
//   reset clears only the valid bits of the pipeline; data registers carry
//   no reset.
// ----------------------------------------------------------------------------
module vector_angle_length #(
  parameter int unsigned COORD_BITS       = 16,
  parameter int unsigned LENGTH_FRAC_BITS = 8,
  parameter int unsigned ANGLE_FRAC_BITS  = 14
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  wire logic [((8*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // length_q8 (25 bits), angle_q14 (16 bits), zero fill
  output logic [47:0]                     m_axis_tdata,
  // degenerate
  output logic                            m_axis_tuser
);

  localparam int unsigned DB   = COORD_BITS + 1;         // difference width
  localparam int unsigned SB   = 2*DB + 1;               // squared sum width
  localparam int unsigned RB   = (SB + 2*LENGTH_FRAC_BITS + 1) / 2; // root bits
  localparam int unsigned PB   = 2*DB + 1;               // dot / cross magnitude
  localparam int unsigned LB   = $clog2(PB + 1);
  localparam int unsigned ALAT = 5 + val_pkg::CordicSteps;
  localparam int unsigned RLAT = RB + 4;
  localparam int unsigned LAT  = (ALAT > RLAT) ? ALAT : RLAT;
  localparam int unsigned ZB   = val_pkg::ZBits;

  logic en;
  logic [LAT+1:0] vld_q;

  // pipeline advances whenever the output slot is free or being taken
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT:0], s_axis_tvalid};
    end
  end

  // ---- stage 0: differences -------------------------------------------------
  logic signed [DB-1:0] ax_q, ay_q, bx_q, by_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= DB'($signed(s_axis_tdata[2*COORD_BITS +: COORD_BITS]))
            - DB'($signed(s_axis_tdata[0*COORD_BITS +: COORD_BITS]));
      ay_q <= DB'($signed(s_axis_tdata[4*COORD_BITS-1 -: COORD_BITS]))
            - DB'($signed(s_axis_tdata[1*COORD_BITS +: COORD_BITS]));
      bx_q <= DB'($signed(s_axis_tdata[6*COORD_BITS +: COORD_BITS]))
            - DB'($signed(s_axis_tdata[4*COORD_BITS +: COORD_BITS]));
      by_q <= DB'($signed(s_axis_tdata[7*COORD_BITS +: COORD_BITS]))
            - DB'($signed(s_axis_tdata[5*COORD_BITS +: COORD_BITS]));
    end
  end

  // ---- stage 1: products ----------------------------------------------------
  logic signed [2*DB-1:0] pxx_q, pyy_q, qxy_q, qyx_q, sax_q, say_q, sbx_q, sby_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      pxx_q <= ax_q * bx_q;
      pyy_q <= ay_q * by_q;
      qxy_q <= ax_q * by_q;
      qyx_q <= ay_q * bx_q;
      sax_q <= ax_q * ax_q;
      say_q <= ay_q * ay_q;
      sbx_q <= bx_q * bx_q;
      sby_q <= by_q * by_q;
    end
  end

  // ---- stage 2: sums --------------------------------------------------------
  logic [SB-1:0] sa_q;
  logic          bzero_q;
  logic signed [PB-1:0] dot_q, crs_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q    <= SB'($unsigned(sax_q)) + SB'($unsigned(say_q));
      bzero_q <= (sbx_q == '0) && (sby_q == '0);
      dot_q   <= PB'(pxx_q) + PB'(pyy_q);
      crs_q   <= PB'(qxy_q) - PB'(qyx_q);
    end
  end

  // ---- square-root lane -----------------------------------------------------
  logic [2*RB-1:0] rnum [RB+1];
  logic [RB-1:0]   rroot [RB+1];
  assign rnum[0]  = (2*RB)'(sa_q) << (2*LENGTH_FRAC_BITS);
  assign rroot[0] = '0;
  for (genvar g = 0; g < RB; g++) begin : g_sqrt
    val_sqrt_stage #(.RootBits(RB), .Bit(RB-1-g)) u_sq (
      .clk_i (clk_i), .en_i (en),
      .num_i (rnum[g]), .root_i (rroot[g]),
      .num_o (rnum[g+1]), .root_o (rroot[g+1])
    );
  end
  // round to nearest: remainder above the root bumps it
  logic [RB:0] len_q;
  always_ff @(posedge clk_i) begin
    if (en) len_q <= (RB+1)'(rroot[RB]) +
      (RB+1)'(rnum[RB] > (2*RB)'(rroot[RB]));
  end
  // delay to the merge stage (root result at stage 3+RB)
  localparam int unsigned LDLY = LAT - (3 + RB);
  logic [RB:0] len_dly [LDLY+1];
  assign len_dly[0] = len_q;
  for (genvar g = 0; g < LDLY; g++) begin : g_ldly
    always_ff @(posedge clk_i) if (en) len_dly[g+1] <= len_dly[g];
  end

  // ---- angle lane: magnitudes and degenerate --------------------------------
  logic [PB-1:0] xm_q, ym_q;
  logic          dneg_q, deg_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      xm_q   <= dot_q[PB-1] ? PB'(-dot_q) : PB'(dot_q);
      ym_q   <= crs_q[PB-1] ? PB'(-crs_q) : PB'(crs_q);
      dneg_q <= dot_q[PB-1];
      deg_q  <= (sa_q == '0) || bzero_q;
    end
  end

  // bit length of the larger, then normalize so msb sits at bit 60
  logic [PB-1:0]  mx;
  logic [LB-1:0]  blen;
  logic [PB+63:0] xn, yn;
  always_comb begin
    mx = (xm_q >= ym_q) ? xm_q : ym_q;
    blen = '0;
    for (int k = 0; k < PB; k++) if (mx[k]) blen = LB'(k + 1);
    // wide magnitudes shift down with truncation, narrow ones shift up
    if (32'(blen) > val_pkg::NormBits) begin
      xn = (PB+64)'(xm_q) >> (32'(blen) - val_pkg::NormBits);
      yn = (PB+64)'(ym_q) >> (32'(blen) - val_pkg::NormBits);
    end else begin
      xn = (PB+64)'(xm_q) << (val_pkg::NormBits - 32'(blen));
      yn = (PB+64)'(ym_q) << (val_pkg::NormBits - 32'(blen));
    end
  end
  logic [63:0] x0_q, y0_q;
  logic        dneg2_q, deg2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q    <= xn[63:0];
      y0_q    <= yn[63:0];
      dneg2_q <= dneg_q;
      deg2_q  <= deg_q;
    end
  end

  logic [63:0] cx [val_pkg::CordicSteps+1];
  logic [63:0] cy [val_pkg::CordicSteps+1];
  logic        cp [val_pkg::CordicSteps+1];
  logic [ZB-1:0] cz [val_pkg::CordicSteps+1];
  logic [val_pkg::CordicSteps:0] cyz, cneg, cdeg;
  assign cx[0] = x0_q;
  assign cy[0] = y0_q;
  assign cp[0] = 1'b1;
  assign cz[0] = '0;
  assign cyz[0]  = (y0_q == '0);
  assign cneg[0] = dneg2_q;
  assign cdeg[0] = deg2_q;
  for (genvar g = 0; g < val_pkg::CordicSteps; g++) begin : g_cordic
    val_cordic_stage #(.Step(g)) u_cs (
      .clk_i (clk_i), .en_i (en),
      .x_i (cx[g]), .y_i (cy[g]), .ypos_i (cp[g]), .z_i (cz[g]),
      .x_o (cx[g+1]), .y_o (cy[g+1]), .ypos_o (cp[g+1]), .z_o (cz[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        cyz[g+1]  <= cyz[g];
        cneg[g+1] <= cneg[g];
        cdeg[g+1] <= cdeg[g];
      end
    end
  end

  // clamp, quadrant fold and round; degenerate items give angle zero
  logic [ZB-1:0] zc;
  logic [ZB-1:0] zf;
  logic [ZB-1:0] zr;
  always_comb begin
    zc = cz[val_pkg::CordicSteps];
    if (cyz[val_pkg::CordicSteps] || zc[ZB-1]) zc = '0;
    else if (zc > val_pkg::Q30HalfPi) zc = val_pkg::Q30HalfPi;
    zf = cneg[val_pkg::CordicSteps] ? val_pkg::Q30Pi - zc : zc;
    zr = (zf + (ZB'(1) << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS);
    if (cdeg[val_pkg::CordicSteps]) zr = '0;
  end
  localparam int unsigned ADLY = LAT - (4 + val_pkg::CordicSteps);
  logic [ZB-1:0] ang_dly [ADLY+1];
  logic          dg_dly  [ADLY+1];
  assign ang_dly[0] = zr;
  assign dg_dly[0]  = cdeg[val_pkg::CordicSteps];
  for (genvar g = 0; g < ADLY; g++) begin : g_adly
    always_ff @(posedge clk_i) begin
      if (en) begin
        ang_dly[g+1] <= ang_dly[g];
        dg_dly[g+1]  <= dg_dly[g];
      end
    end
  end

  // ---- merge / output register ----------------------------------------------
  logic [24:0] len_o_q;
  logic [15:0] ang_o_q;
  logic        deg_o_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      len_o_q <= 25'(len_dly[LDLY]);
      ang_o_q <= 16'(ang_dly[ADLY]);
      deg_o_q <= dg_dly[ADLY];
    end
  end

  assign m_axis_tvalid = vld_q[LAT+1];
  assign m_axis_tdata  = {7'd0, ang_o_q, len_o_q};
  assign m_axis_tuser  = deg_o_q;

endmodule
`default_nettype wire

// ===== rtl/val_sqrt_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// val_sqrt_stage: one registered restoring square-root step
// decides one root bit per stage, remainder kept alongside
// ----------------------------------------------------------------------------
module val_sqrt_stage #(
  parameter int unsigned RootBits = 32,
  parameter int unsigned Bit      = 0
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [2*RootBits-1:0]   num_i,
  input  wire logic [RootBits-1:0]     root_i,
  output logic [2*RootBits-1:0]        num_o,
  output logic [RootBits-1:0]          root_o
);

  logic [RootBits-1:0]   cand;
  logic [2*RootBits+1:0] sq;
  logic [RootBits-1:0]   root_d;

  // (root + 2^b)^2 = root^2 + root*2^(b+1) + 4^b, compared against the residue
  always_comb begin
    cand = root_i | (RootBits'(1) << Bit);
    sq = ((2*RootBits+2)'(root_i) << (Bit + 1)) + ((2*RootBits+2)'(1) << (2*Bit));
    root_d = root_i;
    if (sq <= (2*RootBits+2)'(num_i)) root_d = cand;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_o <= root_d;
      num_o  <= (root_d == root_i) ? num_i : num_i - (2*RootBits)'(sq);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/val_cordic_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// val_cordic_stage: one registered cordic vectoring step
// magnitude and sign form of y, as the angle definition requires
// ----------------------------------------------------------------------------
module val_cordic_stage #(
  parameter int unsigned Step = 0
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [63:0]              x_i,
  input  wire logic [63:0]              y_i,
  input  wire logic                     ypos_i,
  input  wire logic [val_pkg::ZBits-1:0] z_i,
  output logic [63:0]                   x_o,
  output logic [63:0]                   y_o,
  output logic                          ypos_o,
  output logic [val_pkg::ZBits-1:0]     z_o
);

  logic [63:0] xs;
  logic [63:0] ys;
  logic [val_pkg::ZBits-1:0] t;

  assign xs = x_i >> Step;
  assign ys = y_i >> Step;
  assign t  = val_pkg::ZBits'(val_pkg::atan_q30(5'(Step)));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= x_i + ys;
      if (ypos_i) begin
        z_o <= z_i + t;
        if (y_i >= xs) begin
          y_o <= y_i - xs;
          ypos_o <= 1'b1;
        end else begin
          y_o <= xs - y_i;
          ypos_o <= 1'b0;
        end
      end else begin
        z_o <= z_i - t;
        if (xs >= y_i) begin
          y_o <= xs - y_i;
          ypos_o <= 1'b1;
        end else begin
          y_o <= y_i - xs;
          ypos_o <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/val_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// val_checker: port-level checks for vector_angle_length
// ----------------------------------------------------------------------------
module val_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // a free output slot never blocks input
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // degenerate results carry angle zero
  a_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[40:25] == 16'd0)
    else $error("degenerate angle not zero");

  // angle never exceeds pi
  a_pi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[40:25] <= 16'd51472)
    else $error("angle out of range");

endmodule

bind vector_angle_length val_checker u_val_checker (
  .clk_i (clk_i), .rst_ni (rst_ni), .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid), .m_axis_tready (m_axis_tready),
  .m_axis_tdata (m_axis_tdata), .m_axis_tuser (m_axis_tuser)
);
`default_nettype wire

// ===== tb/sv/vector_angle_length_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_angle_length_checker: scoreboard for the vector geometry block
// watches both stream channels, predicts length, angle and degenerate flag
// for every input transfer and compares in order with the output transfers
// ----------------------------------------------------------------------------
module vector_angle_length_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [47:0]  m_axis_tdata,
  input  logic         m_axis_tuser,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    logic [24:0] length;
    logic [15:0] angle;
    logic        degen;
  } geom_t;

  localparam longint AtanQ30 [31] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001};
  localparam longint PiQ30     = 64'd3373259426;
  localparam longint HalfPiQ30 = 64'd1686629713;

  geom_t expected_q[$];
  int    fails;

  // nearest-rounded root of the squared length scaled by 4^8
  function automatic logic [63:0] length_root(input logic [63:0] n);
    logic [127:0] root, cand;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= {64'd0, n}) root = cand;
    end
    if ({64'd0, n} - root * root > root) root = root + 1;
    return root[63:0];
  endfunction

  function automatic logic [15:0] cordic_angle(input logic [63:0] xm, input logic [63:0] ym,
                                               input logic dot_neg);
    logic [127:0] xw, yw, mx;
    logic [63:0]  x, y, xs, ys;
    int           len;
    logic         ypos;
    longint       z;
    mx = (xm >= ym) ? {64'd0, xm} : {64'd0, ym};
    len = 0;
    for (int b = 0; b < 64; b++) if (mx[b]) len = b + 1;
    xw = {64'd0, xm};
    yw = {64'd0, ym};
    if (len > 61) begin
      xw = xw >> (len - 61);
      yw = yw >> (len - 61);
    end else begin
      xw = xw << (61 - len);
      yw = yw << (61 - len);
    end
    x = xw[63:0];
    y = yw[63:0];
    ypos = 1'b1;
    z = 0;
    if (y != 0) begin
      for (int i = 0; i < 31; i++) begin
        xs = x >> i;
        ys = y >> i;
        x = x + ys;
        if (ypos) begin
          z = z + AtanQ30[i];
          if (y >= xs) y = y - xs;
          else begin
            y = xs - y;
            ypos = 1'b0;
          end
        end else begin
          z = z - AtanQ30[i];
          if (xs >= y) begin
            y = xs - y;
            ypos = 1'b1;
          end else y = y - xs;
        end
      end
    end
    if (z < 0) z = 0;
    if (z > HalfPiQ30) z = HalfPiQ30;
    if (dot_neg) z = PiQ30 - z;
    z = (z + (64'd1 << 15)) >>> 16;
    return z[15:0];
  endfunction

  function automatic geom_t predict_geometry(input logic [127:0] d);
    longint ax, ay, bx, by, sa, sb, dot, crs;
    geom_t  r;
    ax = longint'($signed(d[47:32]))   - longint'($signed(d[15:0]));
    ay = longint'($signed(d[63:48]))   - longint'($signed(d[31:16]));
    bx = longint'($signed(d[111:96]))  - longint'($signed(d[79:64]));
    by = longint'($signed(d[127:112])) - longint'($signed(d[95:80]));
    sa = ax * ax + ay * ay;
    sb = bx * bx + by * by;
    r.length = 25'(length_root(sa << 16));
    r.angle = '0;
    r.degen = 1'b0;
    if (sa == 0 || sb == 0) r.degen = 1'b1;
    else begin
      dot = ax * bx + ay * by;
      crs = ax * by - ay * bx;
      r.angle = cordic_angle((dot < 0) ? -dot : dot, (crs < 0) ? -crs : crs, dot < 0);
    end
    return r;
  endfunction

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    geom_t e;
    if (!rst_ni) begin
      fails = 0;
      expected_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result tdata=%h tuser=%b", $time, m_axis_tdata,
                   m_axis_tuser);
          fails++;
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata[24:0] !== e.length) begin
            $display("%0t: length expected %0d actual %0d", $time, e.length,
                     m_axis_tdata[24:0]);
            fails++;
          end
          if (m_axis_tdata[40:25] !== e.angle) begin
            $display("%0t: angle expected %0d actual %0d", $time, e.angle,
                     m_axis_tdata[40:25]);
            fails++;
          end
          if (m_axis_tuser !== e.degen) begin
            $display("%0t: degenerate expected %b actual %b", $time, e.degen,
                     m_axis_tuser);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(predict_geometry(s_axis_tdata));
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for vector_angle_length
// directed corner items then random geometry with bursty stalls on both sides
// ----------------------------------------------------------------------------
module testbench;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // length_q8 (25 bits), angle_q14 (16 bits), zero fill
  logic [47:0]  m_axis_tdata;
  // degenerate
  logic         m_axis_tuser;
  int           fail_count;
  int           pending;
  logic         quiet;      // no idling in the closing part
  logic         long_hold;  // receiver holds off once for a long stretch

  vector_angle_length dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  vector_angle_length_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("vector_angle_length: mismatch");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off while the sender keeps going
  initial begin
    int n;
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold && !held) begin
        m_axis_tready = 1'b0;
        repeat (150) @(negedge clk_i);
        held = 1'b1;
        m_axis_tready = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        n = $urandom_range(1, 4);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // one transfer: optional idle gap, drive at the falling edge, hold until accepted
  task automatic send_geom(input logic [15:0] asx, asy, aex, aey, bsx, bsy, bex, bey);
    int n;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      n = $urandom_range(1, 4);
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {bey, bex, bsy, bsx, aey, aex, asy, asx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rnd_coord(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 16)) - 16'd8;
      default: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    endcase
  endfunction

  initial begin
    int mode, k;
    logic [15:0] sx, sy, ex, ey, tx, ty;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    quiet = 1'b0;
    long_hold = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // both vectors zero, then each one alone zero
    send_geom(0, 0, 0, 0, 0, 0, 0, 0);
    send_geom(5, 5, 5, 5, 0, 0, 3, 4);
    send_geom(0, 0, 3, 4, 7, 7, 7, 7);
    // largest length: full-range diagonal both ways
    send_geom(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_geom(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_geom(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    // parallel, antiparallel, orthogonal, 45 and 135 degrees
    send_geom(0, 0, 1, 0, 0, 0, 9, 0);
    send_geom(0, 0, 1, 0, 0, 0, -9, 0);
    send_geom(0, 0, 1, 0, 0, 0, 0, 1);
    send_geom(0, 0, 1, 0, 0, 0, 0, -1);
    send_geom(0, 0, 1, 0, 0, 0, 1, 1);
    send_geom(0, 0, 1, 0, 0, 0, -1, 1);
    send_geom(0, 0, 0, -1, 0, 0, 0, -3);
    send_geom(0, 0, 3, 4, 0, 0, -4, 3);
    // unit steps and rounding of the root
    send_geom(0, 0, 1, 1, 0, 0, 2, 1);
    send_geom(0, 0, 16'hFFFF, 0, 0, 0, 1, 16'hFFFF);
    send_geom(16'h7FFF, 0, 16'h8000, 0, 0, 16'h7FFF, 0, 16'h8000);
    send_geom(0, 0, 16'h7FFF, 16'h7FFE, 0, 0, 16'h7FFE, 16'h7FFF);

    // random part; the long receiver hold-off lands early on
    for (int i = 0; i < 640; i++) begin
      if (i == 40) long_hold = 1'b1;
      if (i == 560) quiet = 1'b1;
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
        send_geom(rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0),
                  rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0));
      end else if (mode < 7) begin
        send_geom(rnd_coord(1), rnd_coord(1), rnd_coord(1), rnd_coord(1),
                  rnd_coord(1), rnd_coord(1), rnd_coord(1), rnd_coord(1));
      end else if (mode == 7) begin
        // b a scaled copy of a, possibly reversed
        sx = rnd_coord(1) * 16'd100;
        sy = rnd_coord(1) * 16'd100;
        ex = rnd_coord(1);
        ey = rnd_coord(1);
        k = $urandom_range(1, 20);
        tx = 16'(k) * ex;
        ty = 16'(k) * ey;
        if ($urandom_range(0, 1)) begin
          tx = -tx;
          ty = -ty;
        end
        send_geom(sx, sy, sx + ex, sy + ey, 0, 0, tx, ty);
      end else if (mode == 8) begin
        sx = rnd_coord(0);
        sy = rnd_coord(0);
        if ($urandom_range(0, 1))
          send_geom(sx, sy, sx, sy, rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0));
        else
          send_geom(rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0), sx, sy, sx, sy);
      end else begin
        send_geom(rnd_coord(2), rnd_coord(2), rnd_coord(2), rnd_coord(2),
                  rnd_coord(2), rnd_coord(2), rnd_coord(2), rnd_coord(2));
      end
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    // drain, then let the pipeline settle
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("vector_angle_length: match");
    end else begin
      $display("vector_angle_length: mismatch");
    end
    $finish;
  end

endmodule
